[rtl/spbc_pkg.sv]
// Shared types, constants and helper functions of the sphere projection block.
package spbc_pkg;

  localparam int MAX_VERTS = 64;
  localparam int IDX_W     = $clog2(MAX_VERTS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = QPTR_W + 1;
  localparam int DIV_STEPS = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic signed [31:0] TEN_Q16 = 32'sd655360;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    F_LOAD,
    F_WALK,
    F_WAIT
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIFF,
    B_NORM,
    B_SQ,
    B_SQRT,
    B_PMUL,
    B_PGO,
    B_PWAIT,
    B_CGO,
    B_CWAIT,
    B_DONE
  } back_state_e;

  // One stored vertex on its way from the loader to the arithmetic back end.
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } task_t;

  // Mesh-wide context held by the front end while a mesh is emitted.
  typedef struct packed {
    logic signed [2:0][31:0] center;
    logic signed [2:0][31:0] box_min;
    logic signed [2:0][31:0] box_max;
  } mesh_ctx_t;

  typedef struct packed {
    logic [IDX_W-1:0]        vertex_index;
    logic signed [2:0][31:0] sphere;
    logic [2:0][15:0]        color;
    logic signed [31:0]      moved_x;
    logic signed [31:0]      moved_z;
    logic [30:0]             sphere_radius;
    logic                    degenerate;
    logic                    last;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/spbc_front.sv]
// Loader: takes vertices into the store, tracks the box and walks the store on the last vertex.
module spbc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [31:0]     in_x_i,
  input  logic signed [31:0]     in_y_i,
  input  logic signed [31:0]     in_z_i,
  input  logic                   in_last_i,
  input  logic                   cfg_valid_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  output spbc_pkg::task_t        task_o,
  output logic                   task_valid_o,
  input  logic                   task_ready_i,
  output spbc_pkg::mesh_ctx_t    ctx_o,
  input  logic                   mesh_done_i
);

  spbc_pkg::front_state_e state_q, state_d;

  logic [spbc_pkg::CNT_W-1:0] count_q, count_d;
  logic [spbc_pkg::CNT_W-1:0] n_q, n_d;
  logic [spbc_pkg::IDX_W-1:0] walk_q, walk_d;
  logic                       pend_q, pend_d;
  logic signed [2:0][31:0]    min_q, min_d, max_q, max_d;
  logic signed [2:0][31:0]    center_q;

  logic [95:0] mem_q [spbc_pkg::MAX_VERTS];
  logic [95:0] rdata_q;

  logic accept, store, rd_en, walk_last;
  logic signed [2:0][31:0] vin;

  assign vin       = {in_z_i, in_y_i, in_x_i};
  assign accept    = in_valid_i && in_ready_o;
  assign store     = accept && (count_q < spbc_pkg::CNT_W'(spbc_pkg::MAX_VERTS));
  assign walk_last = ({1'b0, walk_q} == n_q - spbc_pkg::CNT_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spbc_pkg::F_LOAD: if (accept && in_last_i) state_d = spbc_pkg::F_WALK;
      spbc_pkg::F_WALK: if (pend_q && walk_last) state_d = spbc_pkg::F_WAIT;
      spbc_pkg::F_WAIT: if (mesh_done_i) state_d = spbc_pkg::F_LOAD;
      default:          state_d = spbc_pkg::F_LOAD;
    endcase
  end

  // Outputs and counters.
  always_comb begin
    in_ready_o   = (state_q == spbc_pkg::F_LOAD);
    rd_en        = (state_q == spbc_pkg::F_WALK) && !pend_q && task_ready_i;
    task_valid_o = (state_q == spbc_pkg::F_WALK) && pend_q;
    count_d = count_q;
    n_d     = n_q;
    walk_d  = walk_q;
    pend_d  = pend_q;
    min_d   = min_q;
    max_d   = max_q;
    if (store) begin
      count_d = count_q + spbc_pkg::CNT_W'(1);
      for (int k = 0; k < 3; k++) begin
        if ($signed(vin[k]) < $signed(min_q[k])) min_d[k] = vin[k];
        if ($signed(vin[k]) > $signed(max_q[k])) max_d[k] = vin[k];
      end
    end
    if (accept && in_last_i) begin
      n_d    = count_d;
      walk_d = '0;
      pend_d = 1'b0;
    end
    if (rd_en) pend_d = 1'b1;
    if (task_valid_o) begin
      pend_d = 1'b0;
      walk_d = walk_q + spbc_pkg::IDX_W'(1);
    end
    if (state_q == spbc_pkg::F_WAIT && mesh_done_i) begin
      count_d = '0;
      for (int k = 0; k < 3; k++) begin
        min_d[k] = 32'sh7FFF_FFFF;
        max_d[k] = 32'sh8000_0000;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= spbc_pkg::F_LOAD;
      count_q  <= '0;
      n_q      <= '0;
      walk_q   <= '0;
      pend_q   <= 1'b0;
      center_q <= '0;
      for (int k = 0; k < 3; k++) begin
        min_q[k] <= 32'sh7FFF_FFFF;
        max_q[k] <= 32'sh8000_0000;
      end
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      walk_q  <= walk_d;
      pend_q  <= pend_d;
      min_q   <= min_d;
      max_q   <= max_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          spbc_pkg::REG_CENTER_X: center_q[0] <= cfg_data_i;
          spbc_pkg::REG_CENTER_Y: center_q[1] <= cfg_data_i;
          spbc_pkg::REG_CENTER_Z: center_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Vertex store.
  always_ff @(posedge clk_i) begin
    if (store) mem_q[count_q[spbc_pkg::IDX_W-1:0]] <= {in_z_i, in_y_i, in_x_i};
    if (rd_en) rdata_q <= mem_q[walk_q];
  end

  always_comb begin
    task_o.idx  = walk_q;
    task_o.x    = rdata_q[31:0];
    task_o.y    = rdata_q[63:32];
    task_o.z    = rdata_q[95:64];
    task_o.last = walk_last;
  end

  assign ctx_o.center  = center_q;
  assign ctx_o.box_min = min_q;
  assign ctx_o.box_max = max_q;

endmodule

[rtl/spbc_fifo.sv]
// Short task queue between the loader and the arithmetic back end.
module spbc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spbc_pkg::task_t push_data_i,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  output spbc_pkg::task_t pop_data_o,
  output logic            pop_valid_o,
  input  logic            pop_ready_i
);

  spbc_pkg::task_t mem_q [spbc_pkg::QDEPTH];
  logic [spbc_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [spbc_pkg::QCNT_W-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = (cnt_q != spbc_pkg::QCNT_W'(spbc_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + spbc_pkg::QPTR_W'(1);
      if (pop)  rd_q <= rd_q + spbc_pkg::QPTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + spbc_pkg::QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - spbc_pkg::QCNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

[rtl/spbc_divider.sv]
// Restoring divider, one quotient bit per cycle, 64-bit dividend over 32-bit divisor.
module spbc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q;
  logic [31:0] den_q, rem_q;
  logic [32:0] trial;
  logic        fits;

  assign trial  = {rem_q, num_q[63]};
  assign fits   = trial >= {1'b0, den_q};
  assign done_o = done_q;
  assign quot_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(spbc_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      num_q <= {num_q[62:0], fits};
    end
  end

endmodule

[rtl/spbc_back.sv]
// Arithmetic back end: projection, colour and offsets for one vertex at a time.
module spbc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spbc_pkg::task_t     task_i,
  input  logic                task_valid_i,
  output logic                task_ready_o,
  input  spbc_pkg::mesh_ctx_t ctx_i,
  output logic                div_start_o,
  output logic [63:0]         div_num_o,
  output logic [31:0]         div_den_o,
  input  logic                div_done_i,
  input  logic [63:0]         div_quot_i,
  output spbc_pkg::result_t   res_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic                mesh_done_o
);

  spbc_pkg::back_state_e state_q, state_d;

  spbc_pkg::task_t         task_q;
  logic [2:0][32:0]        mag_q;
  logic [2:0]              neg_q;
  logic [32:0]             m_q;
  logic                    degen_q;
  logic [63:0]             prod_q, acc_q;
  logic [63:0]             sq_s_q, sq_r_q, sq_bit_q;
  logic [31:0]             len_q;
  logic [1:0]              k_q;
  logic [5:0]              cnt_q;
  logic signed [2:0][31:0] sph_q;
  logic [2:0][15:0]        col_q;
  spbc_pkg::result_t       res_q;
  logic                    res_valid_q;

  logic signed [2:0][31:0] p;
  logic signed [2:0][32:0] dd;
  logic [2:0][32:0]        mag;
  logic [32:0]             m;
  logic [2:0][31:0]        ext;
  logic [2:0][32:0]        off;
  logic [63:0]             sq_t;
  logic                    sq_ge;
  logic                    load_res;
  logic signed [65:0]      proj_sum, mx_sum, mz_sum;

  assign p = {task_q.z, task_q.y, task_q.x};

  always_comb begin
    m = '0;
    for (int k = 0; k < 3; k++) begin
      dd[k]  = {p[k][31], p[k]} - {ctx_i.center[k][31], ctx_i.center[k]};
      mag[k] = dd[k][32] ? 33'(-dd[k]) : 33'(dd[k]);
      if (mag[k] > m) m = mag[k];
      ext[k] = 32'({ctx_i.box_max[k][31], ctx_i.box_max[k]}
                   - {ctx_i.box_min[k][31], ctx_i.box_min[k]});
      off[k] = {p[k][31], p[k]} - {ctx_i.box_min[k][31], ctx_i.box_min[k]};
    end
  end

  assign sq_t  = sq_r_q + sq_bit_q;
  assign sq_ge = sq_s_q >= sq_t;

  assign proj_sum = neg_q[k_q]
                    ? 66'($signed(ctx_i.center[k_q])) - $signed({2'b00, div_quot_i})
                    : 66'($signed(ctx_i.center[k_q])) + $signed({2'b00, div_quot_i});
  assign mx_sum   = 66'($signed(p[0])) - $signed({34'd0, ext[0]})
                    - 66'(spbc_pkg::TEN_Q16);
  assign mz_sum   = 66'($signed(p[2])) + 66'(spbc_pkg::TEN_Q16);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spbc_pkg::B_IDLE: if (task_valid_i) state_d = spbc_pkg::B_DIFF;
      spbc_pkg::B_DIFF: begin
        if (m == '0)       state_d = spbc_pkg::B_CGO;
        else if (m[32:31] != 2'b00) state_d = spbc_pkg::B_SQ;
        else               state_d = spbc_pkg::B_NORM;
      end
      spbc_pkg::B_NORM:  if (m_q[30]) state_d = spbc_pkg::B_SQ;
      spbc_pkg::B_SQ:    if (cnt_q == 6'd3) state_d = spbc_pkg::B_SQRT;
      spbc_pkg::B_SQRT:  if (cnt_q == 6'(spbc_pkg::SQRT_STEPS - 1)) state_d = spbc_pkg::B_PMUL;
      spbc_pkg::B_PMUL:  state_d = spbc_pkg::B_PGO;
      spbc_pkg::B_PGO:   state_d = spbc_pkg::B_PWAIT;
      spbc_pkg::B_PWAIT: begin
        if (div_done_i) state_d = (k_q == 2'd2) ? spbc_pkg::B_CGO : spbc_pkg::B_PMUL;
      end
      spbc_pkg::B_CGO: begin
        if (ext[k_q] != '0)  state_d = spbc_pkg::B_CWAIT;
        else if (k_q == 2'd2) state_d = spbc_pkg::B_DONE;
      end
      spbc_pkg::B_CWAIT: begin
        if (div_done_i) state_d = (k_q == 2'd2) ? spbc_pkg::B_DONE : spbc_pkg::B_CGO;
      end
      spbc_pkg::B_DONE:  if (load_res) state_d = spbc_pkg::B_IDLE;
      default:           state_d = spbc_pkg::B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    task_ready_o = (state_q == spbc_pkg::B_IDLE);
    load_res     = (state_q == spbc_pkg::B_DONE) && (!res_valid_q || res_ready_i);
    mesh_done_o  = load_res && task_q.last;
    div_start_o  = 1'b0;
    div_num_o    = prod_q;
    div_den_o    = len_q;
    if (state_q == spbc_pkg::B_PGO) begin
      div_start_o = 1'b1;
    end else if (state_q == spbc_pkg::B_CGO) begin
      div_start_o = (ext[k_q] != '0);
      div_num_o   = {15'd0, off[k_q], 16'd0};
      div_den_o   = ext[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spbc_pkg::B_IDLE;
      res_valid_q <= 1'b0;
      k_q         <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load_res)         res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
      case (state_q)
        spbc_pkg::B_DIFF: begin
          k_q   <= '0;
          cnt_q <= '0;
        end
        spbc_pkg::B_SQ: begin
          cnt_q <= (cnt_q == 6'd3) ? 6'd0 : cnt_q + 6'd1;
        end
        spbc_pkg::B_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(spbc_pkg::SQRT_STEPS - 1)) k_q <= '0;
        end
        spbc_pkg::B_PWAIT: begin
          if (div_done_i) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        end
        spbc_pkg::B_CGO: begin
          if (ext[k_q] == '0 && k_q != 2'd2) k_q <= k_q + 2'd1;
        end
        spbc_pkg::B_CWAIT: begin
          if (div_done_i && k_q != 2'd2) k_q <= k_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      spbc_pkg::B_IDLE: if (task_valid_i) task_q <= task_i;
      spbc_pkg::B_DIFF: begin
        degen_q <= (m == '0);
        acc_q   <= '0;
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= dd[k][32];
          mag_q[k] <= (m[32:31] != 2'b00) ? (mag[k] >> 1) : mag[k];
          if (m == '0) sph_q[k] <= ctx_i.center[k];
        end
        m_q <= m;
      end
      spbc_pkg::B_NORM: begin
        if (!m_q[30]) begin
          m_q <= m_q << 1;
          for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] << 1;
        end
      end
      spbc_pkg::B_SQ: begin
        if (cnt_q != 6'd3) prod_q <= 64'(mag_q[cnt_q[1:0]][31:0]) * 64'(mag_q[cnt_q[1:0]][31:0]);
        if (cnt_q != 6'd0) acc_q <= acc_q + prod_q;
        if (cnt_q == 6'd3) begin
          sq_s_q   <= acc_q + prod_q;
          sq_r_q   <= '0;
          sq_bit_q <= 64'd1 << 62;
        end
      end
      spbc_pkg::B_SQRT: begin
        sq_s_q   <= sq_ge ? sq_s_q - sq_t : sq_s_q;
        sq_r_q   <= sq_ge ? (sq_r_q >> 1) + sq_bit_q : sq_r_q >> 1;
        sq_bit_q <= sq_bit_q >> 2;
      end
      spbc_pkg::B_PMUL: begin
        prod_q <= 64'(mag_q[k_q][31:0]) * 64'(ext[0][31:1]);
        len_q  <= (sq_r_q[31:0] == '0) ? 32'd1 : sq_r_q[31:0];
      end
      spbc_pkg::B_PWAIT: begin
        if (div_done_i) sph_q[k_q] <= spbc_pkg::sat32(proj_sum);
      end
      spbc_pkg::B_CGO: begin
        if (ext[k_q] == '0) col_q[k_q] <= '0;
      end
      spbc_pkg::B_CWAIT: begin
        if (div_done_i) begin
          col_q[k_q] <= (div_quot_i[63:16] != '0) ? 16'hFFFF : div_quot_i[15:0];
        end
      end
      default: ;
    endcase
    if (load_res) begin
      res_q.vertex_index  <= task_q.idx;
      res_q.sphere        <= sph_q;
      res_q.color         <= col_q;
      res_q.moved_x       <= spbc_pkg::sat32(mx_sum);
      res_q.moved_z       <= spbc_pkg::sat32(mz_sum);
      res_q.sphere_radius <= ext[0][31:1];
      res_q.degenerate    <= degen_q;
      res_q.last          <= task_q.last;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

[rtl/sphere_projection_bbox_color_top.sv]
// Top level of the sphere projection and bounding-box colour block.
//
// Vertices arrive on the slave stream, one per transaction, with x, y and z
// (signed Q16.16) in tdata and tlast marking the final vertex of a mesh.
// While loading, s_axis_tready is high; up to 64 vertices are kept, and
// further ones, even one with tlast, are dropped. The transaction with tlast
// closes the mesh: s_axis_tready then stays low until the last result has
// been produced. The loader walks its store into a four-entry queue,
// pushing each vertex it reads before reading the next, and the back end
// works through each vertex in turn: up to 30 normalising shifts, the sum
// of squares, 32 square-root steps and up to six 64-step divisions on the
// shared divider; a vertex at the centre goes straight to colour divisions.
// Results appear on the master stream, one per stored vertex in load order,
// with the degenerate flag in tuser and tlast on the final vertex. A result
// sits in an output register; a stalling receiver holds it and, once the
// back end has its next result ready, the whole pipeline waits.
// The centre is written through the configuration channel, which is always
// ready and should only be used while no mesh is being processed.
// Reset clears the box, the vertex count and the centre registers; the
// vertex store itself is not cleared, as only written entries are read.
module sphere_projection_bbox_color_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: in_x [31:0], in_y [63:32], in_z [95:64]
  input  logic [95:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: vertex_index [5:0], sphere_x [37:6], sphere_y [69:38],
  // sphere_z [101:70], color_r [117:102], color_g [133:118],
  // color_b [149:134], moved_x [181:150], moved_z [213:182],
  // sphere_radius [244:214], zero padding [247:245]
  output logic [247:0] m_axis_tdata,
  // tuser: degenerate [0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  spbc_pkg::task_t     front_task, back_task;
  logic                front_task_valid, front_task_ready;
  logic                back_task_valid, back_task_ready;
  spbc_pkg::mesh_ctx_t ctx;
  spbc_pkg::result_t   res;
  logic                mesh_done;
  logic                div_start, div_done;
  logic [63:0]         div_num, div_quot;
  logic [31:0]         div_den;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  spbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_x_i       (s_axis_tdata[31:0]),
    .in_y_i       (s_axis_tdata[63:32]),
    .in_z_i       (s_axis_tdata[95:64]),
    .in_last_i    (s_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .task_o       (front_task),
    .task_valid_o (front_task_valid),
    .task_ready_i (front_task_ready),
    .ctx_o        (ctx),
    .mesh_done_i  (mesh_done)
  );

  spbc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_task),
    .push_valid_i (front_task_valid),
    .push_ready_o (front_task_ready),
    .pop_data_o   (back_task),
    .pop_valid_o  (back_task_valid),
    .pop_ready_i  (back_task_ready)
  );

  spbc_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  spbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_i       (back_task),
    .task_valid_i (back_task_valid),
    .task_ready_o (back_task_ready),
    .ctx_i        (ctx),
    .div_start_o  (div_start),
    .div_num_o    (div_num),
    .div_den_o    (div_den),
    .div_done_i   (div_done),
    .div_quot_i   (div_quot),
    .res_o        (res),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .mesh_done_o  (mesh_done)
  );

  // Result packing, lowest field first.
  assign m_axis_tdata = {3'b000, res.sphere_radius, res.moved_z, res.moved_x,
                         res.color[2], res.color[1], res.color[0],
                         res.sphere[2], res.sphere[1], res.sphere[0],
                         res.vertex_index};
  assign m_axis_tuser = res.degenerate;
  assign m_axis_tlast = res.last;

endmodule

[rtl/spbc_checker.sv]
// Port-level checks of the sphere projection block, bound to its top level.
module spbc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [247:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // A result offered must stay offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before transaction");

  // A stalled result must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Taking the last vertex of a mesh must pull s_axis_tready low.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("vertex accepted right after the last vertex");

  // No result while a mesh is still loading without a pending emission.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && $past(s_axis_tready) |-> !m_axis_tvalid || !$past(m_axis_tvalid)
                                              || !$past(m_axis_tready))
    else $error("result produced while loading");

endmodule

bind sphere_projection_bbox_color_top spbc_checker u_spbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
